### rtl/cartesian_to_spherical_angles_core_macros.svh
// Assertion macros for the cartesian to spherical angles core RTL.
`ifndef CARTESIAN_TO_SPHERICAL_ANGLES_CORE_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_ANGLES_CORE_MACROS_SVH

// Check a property on the rising clock edge, off while reset is low.
`define C2SA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define C2SA_ASSERT_IMPL(label, ante, cons, msg) \
    `C2SA_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/c2sa_pkg.sv
// Package: types, output widths and elaboration-time CORDIC constants.
`default_nettype none

package c2sa_pkg;

    localparam int DATA_W    = 64;
    localparam int POLAR_W   = 14;
    localparam int AZIMUTH_W = 16;
    localparam int OUT_W     = 32;
    localparam int Q_BITS    = 60;
    localparam int GUARD_TOP = 58;
    localparam int PP_SPLIT  = 29;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic                 zero_vec;
        logic                 x_zero;
        logic                 y_zero;
        logic                 y_neg;
        logic                 z_pos;
        logic                 rlen_zero;
        logic [AZIMUTH_W-1:0] phi;
        data_t                zg;
    } side_t;

    // Restoring division, only ever evaluated on constants.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q60 by its power series.
    function automatic data_t atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] nn;
        logic [63:0] k;
        data_t       sum;
        p   = udiv64(64'd1 << Q_BITS, n);
        nn  = n * n;
        sum = data_t'(p);
        k   = 64'd1;
        while (p != 64'd0)
        begin
            p = udiv64(p, nn);
            if (k[0])
                sum = sum - data_t'(udiv64(p, 2 * k + 64'd1));
            else
                sum = sum + data_t'(udiv64(p, 2 * k + 64'd1));
            k = k + 64'd1;
        end
        return sum;
    endfunction

    function automatic data_t quarter_pi();
        return atan_recip(64'd2) + atan_recip(64'd3);
    endfunction

    function automatic data_t atan_tab(input int i);
        if (i == 0)
            return quarter_pi();
        return atan_recip(64'd1 << i);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] bitv;
        v    = v_in;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // CORDIC gain at the guard scale of the components.
    function automatic logic [63:0] gain_scaled(input int stages, input int guard);
        logic [63:0] prod;
        logic [63:0] g30;
        prod = 64'd1 << Q_BITS;
        for (int i = 0; i < stages; i++)
            prod = prod + (prod >> (2 * i));
        g30 = isqrt64(prod);
        if (guard >= 30)
            return g30 << (guard - 30);
        return g30 >> (30 - guard);
    endfunction

    // Round a Q60 angle half up to f fraction bits.
    function automatic data_t round_angle(input data_t v, input int f);
        return (v + (data_t'(1) <<< (59 - f))) >>> (Q_BITS - f);
    endfunction

endpackage

`default_nettype wire

### rtl/c2sa_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation.
`default_nettype none

module c2sa_cordic_stage #(
    parameter int              SHIFT = 0,
    parameter c2sa_pkg::data_t ANGLE = '0
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire c2sa_pkg::data_t a_in,
    input  wire c2sa_pkg::data_t b_in,
    input  wire c2sa_pkg::data_t ang_in,
    output c2sa_pkg::data_t      a_reg,
    output c2sa_pkg::data_t      b_reg,
    output c2sa_pkg::data_t      ang_reg
);

    c2sa_pkg::data_t a_next;
    c2sa_pkg::data_t b_next;
    c2sa_pkg::data_t ang_next;

    // Rotate toward the positive a axis; the sign of b picks the direction.
    always_comb
    begin
        if (!b_in[c2sa_pkg::DATA_W-1])
        begin
            a_next   = a_in + (b_in >>> SHIFT);
            b_next   = b_in - (a_in >>> SHIFT);
            ang_next = ang_in + ANGLE;
        end
        else
        begin
            a_next   = a_in - (b_in >>> SHIFT);
            b_next   = b_in + (a_in >>> SHIFT);
            ang_next = ang_in - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            ang_reg <= ang_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cartesian_to_spherical_angles_core.sv
// Top level: pipelined cartesian to spherical angle converter (theta, phi).
//
//  channel | dir | word
//  --------+-----+--------------------------------------------------------
//  s_axis  | in  | tdata: x_component, y_component, z_component
//  m_axis  | out | tdata: polar_angle, azimuth_angle; tuser: zero_vector
//
//  The pipeline has one input stage, one CORDIC stage per rotation for phi,
//  one stage for phi rounding, one per rotation for theta, one output stage.
//  One word enters every cycle unless a full pipe is stalled at the output; each stage holds
//  when its successor is full and stalled, so bubbles collapse and nothing is dropped or repeated.
//  Reset clears the valid bits only; no clearing pass.
`default_nettype none
`include "cartesian_to_spherical_angles_core_macros.svh"

module cartesian_to_spherical_angles_core #(
    parameter int COMPONENT_BITS      = 16,
    parameter int ANGLE_FRACTION_BITS = 12,
    parameter int ROTATION_STAGES     = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // x_component, y_component, z_component from bit 0 up
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // polar_angle, azimuth_angle, zero padding from bit 0 up
    output logic [c2sa_pkg::OUT_W-1:0]                    m_axis_tdata,
    // zero_vector
    output logic                                          m_axis_tuser
);

    localparam int CB    = COMPONENT_BITS;
    localparam int RS    = ROTATION_STAGES;
    localparam int NST   = 2 * RS + 3;
    localparam int LAST  = NST - 1;
    localparam int MID   = RS + 1;
    localparam int GUARD = c2sa_pkg::GUARD_TOP - CB;
    localparam int SPLIT = c2sa_pkg::PP_SPLIT;
    localparam int GAIN_W = GUARD + 1;
    localparam int HI_W  = (GAIN_W > SPLIT) ? GAIN_W - SPLIT : 1;
    localparam int PW    = c2sa_pkg::POLAR_W;
    localparam int AW    = c2sa_pkg::AZIMUTH_W;

    localparam c2sa_pkg::data_t QUARTER = c2sa_pkg::quarter_pi();
    localparam c2sa_pkg::data_t HALF_PI = QUARTER * 2;
    localparam c2sa_pkg::data_t PI_F =
        c2sa_pkg::round_angle(QUARTER * 4, ANGLE_FRACTION_BITS);
    localparam c2sa_pkg::data_t HALF_PI_F =
        c2sa_pkg::round_angle(HALF_PI, ANGLE_FRACTION_BITS);
    localparam c2sa_pkg::data_t THREE_HALF_PI_F =
        c2sa_pkg::round_angle(QUARTER * 6, ANGLE_FRACTION_BITS);
    localparam logic [63:0] GAIN_G = c2sa_pkg::gain_scaled(RS, GUARD);
    localparam logic [PW-1:0] PI_F_OUT = PI_F[PW-1:0];

    // Valid bits and per-stage advance (stage empty or successor advancing).
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] adv;

    // CORDIC state per stage and side data that rides along.
    c2sa_pkg::data_t a_reg   [0:2*RS+1];
    c2sa_pkg::data_t b_reg   [0:2*RS+1];
    c2sa_pkg::data_t ang_reg [0:2*RS+1];
    c2sa_pkg::side_t side_reg [0:2*RS+1];

    logic signed [CB+SPLIT:0]  pp_lo_reg;
    logic signed [CB+HI_W:0]   pp_hi_reg;

    logic [PW-1:0] polar_reg;
    logic [AW-1:0] azimuth_reg;
    logic          zero_reg;

    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
        valid_next[0] = adv[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NST; k++)
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // ---------------- input stage: unpack, quadrant fold, gain products
    logic signed [CB-1:0] x_s;
    logic signed [CB-1:0] y_s;
    logic signed [CB-1:0] z_s;
    c2sa_pkg::data_t      ax;
    c2sa_pkg::data_t      by;
    c2sa_pkg::data_t      a0_next;
    c2sa_pkg::data_t      b0_next;
    c2sa_pkg::data_t      ang0_next;
    c2sa_pkg::side_t      side0_next;
    logic signed [SPLIT:0] gain_lo;
    logic signed [HI_W:0]  gain_hi;

    assign gain_lo = $signed({1'b0, GAIN_G[SPLIT-1:0]});
    assign gain_hi = $signed({1'b0, GAIN_G[SPLIT +: HI_W]});

    always_comb
    begin
        x_s = s_axis_tdata[CB-1:0];
        y_s = s_axis_tdata[2*CB-1:CB];
        z_s = s_axis_tdata[3*CB-1:2*CB];
        ax  = c2sa_pkg::data_t'(x_s) <<< GUARD;
        by  = c2sa_pkg::data_t'(y_s) <<< GUARD;
        // Fold the left half plane onto the right by a quarter turn.
        if (x_s[CB-1])
        begin
            if (!y_s[CB-1])
            begin
                a0_next   = by;
                b0_next   = -ax;
                ang0_next = HALF_PI;
            end
            else
            begin
                a0_next   = -by;
                b0_next   = ax;
                ang0_next = -HALF_PI;
            end
        end
        else
        begin
            a0_next   = ax;
            b0_next   = by;
            ang0_next = '0;
        end
        side0_next           = '0;
        side0_next.x_zero    = (x_s == '0);
        side0_next.y_zero    = (y_s == '0);
        side0_next.y_neg     = y_s[CB-1];
        side0_next.z_pos     = !z_s[CB-1] && (z_s != '0);
        side0_next.zero_vec  = (x_s == '0) && (y_s == '0) && (z_s == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg[0]    <= a0_next;
            b_reg[0]    <= b0_next;
            ang_reg[0]  <= ang0_next;
            side_reg[0] <= side0_next;
            pp_lo_reg   <= z_s * gain_lo;
            pp_hi_reg   <= z_s * gain_hi;
        end
    end

    // ---------------- phi pass
    c2sa_pkg::side_t side1_next;

    always_comb
    begin
        side1_next    = side_reg[0];
        // Sum the two partial products of z times gain.
        side1_next.zg = (c2sa_pkg::data_t'(pp_hi_reg) <<< SPLIT)
                      + c2sa_pkg::data_t'(pp_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
            side_reg[1] <= side1_next;
    end

    for (genvar i = 0; i < RS; i++)
    begin : g_phi
        c2sa_cordic_stage #(
            .SHIFT (i),
            .ANGLE (c2sa_pkg::atan_tab(i))
        ) u_stage (
            .clk     (clk),
            .en      (adv[i+1]),
            .a_in    (a_reg[i]),
            .b_in    (b_reg[i]),
            .ang_in  (ang_reg[i]),
            .a_reg   (a_reg[i+1]),
            .b_reg   (b_reg[i+1]),
            .ang_reg (ang_reg[i+1])
        );
        if (i > 0)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (adv[i+1])
                    side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // ---------------- middle stage: round phi, fold (gain*z, r) for theta
    c2sa_pkg::data_t phi_round;
    c2sa_pkg::data_t phi_sel;
    c2sa_pkg::data_t rlen;
    c2sa_pkg::data_t zg;
    c2sa_pkg::side_t mid_side;
    c2sa_pkg::data_t am_next;
    c2sa_pkg::data_t bm_next;
    c2sa_pkg::data_t angm_next;

    always_comb
    begin
        mid_side  = side_reg[RS];
        rlen      = a_reg[RS];
        zg        = mid_side.zg;
        phi_round = c2sa_pkg::round_angle(ang_reg[RS], ANGLE_FRACTION_BITS);
        if (phi_round > PI_F)
            phi_sel = PI_F;
        else if (phi_round < -PI_F)
            phi_sel = -PI_F;
        else
            phi_sel = phi_round;
        // In the plane x = 0: quarter turn for positive y, three-quarter turn for negative y, zero if y = 0.
        if (mid_side.x_zero)
        begin
            if (mid_side.y_zero)
                phi_sel = '0;
            else if (mid_side.y_neg)
                phi_sel = THREE_HALF_PI_F;
            else
                phi_sel = HALF_PI_F;
        end
        mid_side.phi       = phi_sel[AW-1:0];
        mid_side.rlen_zero = (rlen == '0);
        if (zg[c2sa_pkg::DATA_W-1])
        begin
            if (!rlen[c2sa_pkg::DATA_W-1])
            begin
                am_next   = rlen;
                bm_next   = -zg;
                angm_next = HALF_PI;
            end
            else
            begin
                am_next   = -rlen;
                bm_next   = zg;
                angm_next = -HALF_PI;
            end
        end
        else
        begin
            am_next   = zg;
            bm_next   = rlen;
            angm_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[MID])
        begin
            a_reg[MID]    <= am_next;
            b_reg[MID]    <= bm_next;
            ang_reg[MID]  <= angm_next;
            side_reg[MID] <= mid_side;
        end
    end

    // ---------------- theta pass
    for (genvar i = 0; i < RS; i++)
    begin : g_theta
        c2sa_cordic_stage #(
            .SHIFT (i),
            .ANGLE (c2sa_pkg::atan_tab(i))
        ) u_stage (
            .clk     (clk),
            .en      (adv[MID+1+i]),
            .a_in    (a_reg[MID+i]),
            .b_in    (b_reg[MID+i]),
            .ang_in  (ang_reg[MID+i]),
            .a_reg   (a_reg[MID+1+i]),
            .b_reg   (b_reg[MID+1+i]),
            .ang_reg (ang_reg[MID+1+i])
        );
        always_ff @(posedge clk)
        begin
            if (adv[MID+1+i])
                side_reg[MID+1+i] <= side_reg[MID+i];
        end
    end

    // ---------------- output stage: round and clamp theta, special cases
    c2sa_pkg::data_t theta_round;
    c2sa_pkg::data_t theta_sel;
    c2sa_pkg::side_t out_side;

    always_comb
    begin
        out_side    = side_reg[2*RS+1];
        theta_round = c2sa_pkg::round_angle(ang_reg[2*RS+1], ANGLE_FRACTION_BITS);
        if (theta_round < 0)
            theta_sel = '0;
        else if (theta_round > PI_F)
            theta_sel = PI_F;
        else
            theta_sel = theta_round;
        // On the z axis: straight up or straight down.
        if (out_side.rlen_zero)
            theta_sel = out_side.z_pos ? '0 : PI_F;
        if (out_side.zero_vec)
            theta_sel = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            polar_reg   <= theta_sel[PW-1:0];
            azimuth_reg <= out_side.zero_vec ? '0 : out_side.phi;
            zero_reg    <= out_side.zero_vec;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {{(c2sa_pkg::OUT_W-PW-AW){1'b0}}, azimuth_reg, polar_reg};
    assign m_axis_tuser  = zero_reg;

    // ---------------- assertions
    `C2SA_ASSERT_IMPL(a_zero_angles, m_axis_tvalid && zero_reg, polar_reg == '0 && azimuth_reg == '0, "zero vector with nonzero angle")
    `C2SA_ASSERT_IMPL(a_polar_range, m_axis_tvalid, polar_reg <= PI_F_OUT, "polar angle above pi")
    `C2SA_ASSERT_IMPL(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready && (&valid_reg), "input held while pipe has room")

endmodule

`default_nettype wire
